FILE: rtl/core/tfn_pkg.sv
// tfn_pkg: widths and payload types shared by the face normal datapath.
// No dependencies.
`default_nettype none
package tfn_pkg;

  localparam int PROD_W  = 64;
  localparam int MAG_W   = 30;
  localparam int SQR_W   = 60;
  localparam int SUM_W   = 62;
  localparam int ROOT_W  = 31;
  localparam int REM_W   = 33;
  localparam int OUT_FRAC = 14;
  localparam int NUM_W   = 46;
  localparam int Q_W     = 15;
  localparam int OUT_W   = 16;
  localparam int IDX_W   = 16;
  localparam logic [Q_W-1:0] NORM_ONE = 15'd16384;

  typedef logic [MAG_W-1:0] mag_t;

  typedef struct packed {
    logic [IDX_W-1:0] ia;
    logic [IDX_W-1:0] ib;
    logic [IDX_W-1:0] ic;
    logic [2:0]       neg;
    logic             degen;
  } pay_t;

endpackage
`default_nettype wire

FILE: rtl/core/tfn_norm_cell.sv
// tfn_norm_cell: one step of the leading-one normalizer, shifts left by SH
// when the top SH bits of the running maximum are clear. Uses tfn_pkg.
`default_nettype none
module tfn_norm_cell #(
  parameter int SH = 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              v_in,
  input  tfn_pkg::pay_t                     pay_in,
  input  logic [tfn_pkg::PROD_W-1:0]        mx_in,
  input  logic [2:0][tfn_pkg::PROD_W-1:0]   m_in,
  output logic                              v_out,
  output tfn_pkg::pay_t                     pay_out,
  output logic [tfn_pkg::PROD_W-1:0]        mx_out,
  output logic [2:0][tfn_pkg::PROD_W-1:0]   m_out
);

  logic do_shift;
  assign do_shift = (mx_in[tfn_pkg::PROD_W-1 -: SH] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    pay_out <= pay_in;
    if (do_shift) begin
      mx_out <= mx_in << SH;
      for (int j = 0; j < 3; j++) m_out[j] <= m_in[j] << SH;
    end else begin
      mx_out <= mx_in;
      m_out  <= m_in;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/tfn_sqrt_cell.sv
// tfn_sqrt_cell: one root bit of the pipelined restoring square root.
// Uses tfn_pkg.
`default_nettype none
module tfn_sqrt_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          v_in,
  input  tfn_pkg::pay_t                 pay_in,
  input  tfn_pkg::mag_t [2:0]           m_in,
  input  logic [tfn_pkg::SUM_W-1:0]     rad_in,
  input  logic [tfn_pkg::REM_W-1:0]     rem_in,
  input  logic [tfn_pkg::ROOT_W-1:0]    root_in,
  output logic                          v_out,
  output tfn_pkg::pay_t                 pay_out,
  output tfn_pkg::mag_t [2:0]           m_out,
  output logic [tfn_pkg::SUM_W-1:0]     rad_out,
  output logic [tfn_pkg::REM_W-1:0]     rem_out,
  output logic [tfn_pkg::ROOT_W-1:0]    root_out
);

  localparam int TW = tfn_pkg::REM_W + 2;

  logic [TW-1:0] trial;
  logic [TW-1:0] test;
  logic          fits;

  assign trial = {rem_in, rad_in[tfn_pkg::SUM_W-1 -: 2]};
  assign test  = TW'({root_in, 2'b01});
  assign fits  = (trial >= test);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    pay_out  <= pay_in;
    m_out    <= m_in;
    rad_out  <= rad_in << 2;
    rem_out  <= fits ? tfn_pkg::REM_W'(trial - test) : trial[tfn_pkg::REM_W-1:0];
    root_out <= {root_in[tfn_pkg::ROOT_W-2:0], fits};
  end

endmodule
`default_nettype wire

FILE: rtl/core/tfn_div_cell.sv
// tfn_div_cell: one quotient bit for all three components of the
// pipelined restoring divider. Uses tfn_pkg.
`default_nettype none
module tfn_div_cell #(
  parameter int SH = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                v_in,
  input  tfn_pkg::pay_t                       pay_in,
  input  logic [tfn_pkg::ROOT_W-1:0]          len_in,
  input  logic [2:0][tfn_pkg::NUM_W-1:0]      rem_in,
  input  logic [2:0][tfn_pkg::Q_W-1:0]        q_in,
  output logic                                v_out,
  output tfn_pkg::pay_t                       pay_out,
  output logic [tfn_pkg::ROOT_W-1:0]          len_out,
  output logic [2:0][tfn_pkg::NUM_W-1:0]      rem_out,
  output logic [2:0][tfn_pkg::Q_W-1:0]        q_out
);

  logic [tfn_pkg::NUM_W-1:0] dvs;
  assign dvs = tfn_pkg::NUM_W'(len_in) << SH;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    pay_out <= pay_in;
    len_out <= len_in;
    for (int j = 0; j < 3; j++) begin
      if (rem_in[j] >= dvs) begin
        rem_out[j] <= rem_in[j] - dvs;
        q_out[j]   <= {q_in[j][tfn_pkg::Q_W-2:0], 1'b1};
      end else begin
        rem_out[j] <= rem_in[j];
        q_out[j]   <= {q_in[j][tfn_pkg::Q_W-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/triangle_face_normal_top.sv
// triangle_face_normal_top: flat face normal, edges, cross product,
// normalize, square root and divide chains. Uses tfn_pkg and the cells.
//
//   channel | handshake           | word
//   input   | start, busy         | first_*, second_*, third_*, vertex_index_*
//   config  | cfg_valid, cfg_ready| cfg_data (flat_normals_enable)
//   result  | done (one cycle)    | normal_*, target_index_*, degenerate
//
// One triangle per cycle; busy is never raised. The root chain has 31 cells
// and the divider chain has 15 cells.
// Reset is synchronous and clears all valid bits; enable resets to 1.
// The result side cannot stall; each result shows for one cycle.
`default_nettype none
module triangle_face_normal_top #(
  parameter int INDEX_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [31:0]      first_x,
  input  logic signed [31:0]      first_y,
  input  logic signed [31:0]      first_z,
  input  logic signed [31:0]      second_x,
  input  logic signed [31:0]      second_y,
  input  logic signed [31:0]      second_z,
  input  logic signed [31:0]      third_x,
  input  logic signed [31:0]      third_y,
  input  logic signed [31:0]      third_z,
  input  logic [INDEX_BITS-1:0]   vertex_index_a,
  input  logic [INDEX_BITS-1:0]   vertex_index_b,
  input  logic [INDEX_BITS-1:0]   vertex_index_c,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_data,
  output logic                    done,
  output logic signed [15:0]      normal_x,
  output logic signed [15:0]      normal_y,
  output logic signed [15:0]      normal_z,
  output logic [15:0]             target_index_a,
  output logic [15:0]             target_index_b,
  output logic [15:0]             target_index_c,
  output logic                    degenerate
);

  localparam int KEEP = (INDEX_BITS < tfn_pkg::IDX_W) ? INDEX_BITS : tfn_pkg::IDX_W;
  localparam int NSQ  = tfn_pkg::ROOT_W;
  localparam int NDV  = tfn_pkg::Q_W;
  localparam int PW   = tfn_pkg::PROD_W;

  logic enable;
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      enable <= cfg_data;
    end
  end

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) return d[32] ? 32'sh80000000 : 32'sh7fffffff;
    return d[31:0];
  endfunction

  // edges
  logic                    v1;
  tfn_pkg::pay_t           pay1;
  logic signed [31:0]      e1 [3];
  logic signed [31:0]      e2 [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start && !busy && enable;
  end

  always_ff @(posedge clk) begin
    pay1.ia    <= tfn_pkg::IDX_W'(vertex_index_a[KEEP-1:0]);
    pay1.ib    <= tfn_pkg::IDX_W'(vertex_index_b[KEEP-1:0]);
    pay1.ic    <= tfn_pkg::IDX_W'(vertex_index_c[KEEP-1:0]);
    pay1.neg   <= '0;
    pay1.degen <= 1'b0;
    e1[0] <= sat_sub(second_x, first_x);
    e1[1] <= sat_sub(second_y, first_y);
    e1[2] <= sat_sub(second_z, first_z);
    e2[0] <= sat_sub(third_x, first_x);
    e2[1] <= sat_sub(third_y, first_y);
    e2[2] <= sat_sub(third_z, first_z);
  end

  // products
  logic               v2;
  tfn_pkg::pay_t      pay2;
  logic signed [PW-1:0] pr [6];

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
  end

  always_ff @(posedge clk) begin
    pay2  <= pay1;
    pr[0] <= PW'(e1[1]) * PW'(e2[2]);
    pr[1] <= PW'(e1[2]) * PW'(e2[1]);
    pr[2] <= PW'(e1[2]) * PW'(e2[0]);
    pr[3] <= PW'(e1[0]) * PW'(e2[2]);
    pr[4] <= PW'(e1[0]) * PW'(e2[1]);
    pr[5] <= PW'(e1[1]) * PW'(e2[0]);
  end

  // cross product magnitudes
  logic                     v3;
  tfn_pkg::pay_t            pay3;
  tfn_pkg::pay_t            pay3_next;
  logic [2:0][PW-1:0]       mag3;
  logic signed [PW:0]       cd [3];

  always_comb begin
    pay3_next = pay2;
    for (int j = 0; j < 3; j++) begin
      cd[j] = (PW+1)'(pr[2*j]) - (PW+1)'(pr[2*j+1]);
      pay3_next.neg[j] = cd[j][PW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
  end

  always_ff @(posedge clk) begin
    pay3 <= pay3_next;
    for (int j = 0; j < 3; j++) begin
      mag3[j] <= cd[j][PW] ? PW'(-cd[j]) : PW'(cd[j]);
    end
  end

  // maximum
  logic                 v4;
  tfn_pkg::pay_t        pay4;
  tfn_pkg::pay_t        pay4_next;
  logic [2:0][PW-1:0]   mag4;
  logic [PW-1:0]        mx4;
  logic [PW-1:0]        mx01;
  logic [PW-1:0]        mxa;

  assign mx01 = (mag3[0] > mag3[1]) ? mag3[0] : mag3[1];
  assign mxa  = (mx01 > mag3[2]) ? mx01 : mag3[2];

  always_comb begin
    pay4_next       = pay3;
    pay4_next.degen = (mxa == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
  end

  always_ff @(posedge clk) begin
    pay4 <= pay4_next;
    mag4 <= mag3;
    mx4  <= mxa;
  end

  // normalizer chain: leading one to the top bit
  logic                 nv  [7];
  tfn_pkg::pay_t        np  [7];
  logic [PW-1:0]        nmx [7];
  logic [2:0][PW-1:0]   nm  [7];

  assign nv[0]  = v4;
  assign np[0]  = pay4;
  assign nmx[0] = mx4;
  assign nm[0]  = mag4;

  for (genvar k = 0; k < 6; k++) begin : g_norm
    tfn_norm_cell #(.SH(32 >> k)) u_cell (
      .clk(clk), .rst(rst),
      .v_in(nv[k]), .pay_in(np[k]), .mx_in(nmx[k]), .m_in(nm[k]),
      .v_out(nv[k+1]), .pay_out(np[k+1]), .mx_out(nmx[k+1]), .m_out(nm[k+1])
    );
  end

  // squares and sum
  logic                        v5;
  tfn_pkg::pay_t               pay5;
  tfn_pkg::mag_t [2:0]         ms5;
  logic [tfn_pkg::SQR_W-1:0]   sq5 [3];
  tfn_pkg::mag_t [2:0]         msn;

  always_comb begin
    for (int j = 0; j < 3; j++) msn[j] = nm[6][j][PW-1 -: tfn_pkg::MAG_W];
  end

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= nv[6];
  end

  always_ff @(posedge clk) begin
    pay5 <= np[6];
    ms5  <= msn;
    for (int j = 0; j < 3; j++)
      sq5[j] <= tfn_pkg::SQR_W'(msn[j]) * tfn_pkg::SQR_W'(msn[j]);
  end

  logic                        v6;
  tfn_pkg::pay_t               pay6;
  tfn_pkg::mag_t [2:0]         ms6;
  logic [tfn_pkg::SUM_W-1:0]   sum6;

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
  end

  always_ff @(posedge clk) begin
    pay6 <= pay5;
    ms6  <= ms5;
    sum6 <= tfn_pkg::SUM_W'(sq5[0]) + tfn_pkg::SUM_W'(sq5[1]) + tfn_pkg::SUM_W'(sq5[2]);
  end

  // root chain
  logic                          sv   [NSQ+1];
  tfn_pkg::pay_t                 sp   [NSQ+1];
  tfn_pkg::mag_t [2:0]           sm   [NSQ+1];
  logic [tfn_pkg::SUM_W-1:0]     srad [NSQ+1];
  logic [tfn_pkg::REM_W-1:0]     srem [NSQ+1];
  logic [tfn_pkg::ROOT_W-1:0]    sroot[NSQ+1];

  assign sv[0]    = v6;
  assign sp[0]    = pay6;
  assign sm[0]    = ms6;
  assign srad[0]  = sum6;
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
    tfn_sqrt_cell u_cell (
      .clk(clk), .rst(rst),
      .v_in(sv[k]), .pay_in(sp[k]), .m_in(sm[k]),
      .rad_in(srad[k]), .rem_in(srem[k]), .root_in(sroot[k]),
      .v_out(sv[k+1]), .pay_out(sp[k+1]), .m_out(sm[k+1]),
      .rad_out(srad[k+1]), .rem_out(srem[k+1]), .root_out(sroot[k+1])
    );
  end

  // divider setup: m * 2^14 + len / 2
  logic                             dv   [NDV+1];
  tfn_pkg::pay_t                    dp   [NDV+1];
  logic [tfn_pkg::ROOT_W-1:0]       dlen [NDV+1];
  logic [2:0][tfn_pkg::NUM_W-1:0]   drem [NDV+1];
  logic [2:0][tfn_pkg::Q_W-1:0]     dq   [NDV+1];

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else     dv[0] <= sv[NSQ];
  end

  always_ff @(posedge clk) begin
    dp[0]   <= sp[NSQ];
    dlen[0] <= sroot[NSQ];
    dq[0]   <= '0;
    for (int j = 0; j < 3; j++)
      drem[0][j] <= (tfn_pkg::NUM_W'(sm[NSQ][j]) << tfn_pkg::OUT_FRAC)
                    + tfn_pkg::NUM_W'(sroot[NSQ] >> 1);
  end

  for (genvar k = 0; k < NDV; k++) begin : g_div
    tfn_div_cell #(.SH(NDV - 1 - k)) u_cell (
      .clk(clk), .rst(rst),
      .v_in(dv[k]), .pay_in(dp[k]), .len_in(dlen[k]), .rem_in(drem[k]), .q_in(dq[k]),
      .v_out(dv[k+1]), .pay_out(dp[k+1]), .len_out(dlen[k+1]),
      .rem_out(drem[k+1]), .q_out(dq[k+1])
    );
  end

  // output register
  logic [tfn_pkg::Q_W-1:0]   nq  [3];
  logic [tfn_pkg::OUT_W-1:0] nout[3];
  tfn_pkg::pay_t             pf;

  assign pf = dp[NDV];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nq[j] = (dq[NDV][j] > tfn_pkg::NORM_ONE) ? tfn_pkg::NORM_ONE : dq[NDV][j];
      if (pf.degen) nq[j] = '0;
      nout[j] = pf.neg[j] ? tfn_pkg::OUT_W'(-{1'b0, nq[j]}) : tfn_pkg::OUT_W'(nq[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= dv[NDV];
  end

  always_ff @(posedge clk) begin
    normal_x       <= nout[0];
    normal_y       <= nout[1];
    normal_z       <= nout[2];
    target_index_a <= pf.ia;
    target_index_b <= pf.ib;
    target_index_c <= pf.ic;
    degenerate     <= pf.degen;
  end

endmodule
`default_nettype wire

FILE: rtl/core/tfn_checker.sv
// tfn_checker: port-level checks of the face normal block, bound to
// triangle_face_normal_top. No package dependency.
`default_nettype none
module tfn_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input logic               degenerate,
  input logic signed [15:0] normal_x,
  input logic signed [15:0] normal_y,
  input logic signed [15:0] normal_z
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (normal_x == 0 && normal_y == 0 && normal_z == 0))
    else $error("degenerate word with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (normal_x <= 16384 && normal_x >= -16384 &&
              normal_y <= 16384 && normal_y >= -16384 &&
              normal_z <= 16384 && normal_z >= -16384))
    else $error("normal component out of range");

  a_unit: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |-> (normal_x >= 9000 || normal_x <= -9000 ||
                               normal_y >= 9000 || normal_y <= -9000 ||
                               normal_z >= 9000 || normal_z <= -9000))
    else $error("non-degenerate normal too short");

  a_never_busy: assert property (@(posedge clk) $past(done) |-> !busy)
    else $error("busy raised");

endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
  .clk(clk), .rst(rst), .busy(busy), .done(done), .degenerate(degenerate),
  .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
);
`default_nettype wire
